FILE: rtl/core/sftf_pkg.sv
// Shared types and helpers for the sender flow table filter.
// Holds the controller/datapath command and status structs and the lane encoder.
// No dependencies.
`timescale 1ns / 1ps

package sftf_pkg;

  // Slots examined per scan cycle, and the width of a lane index.
  localparam int LANE_MAX = 16;
  localparam int LANE_W = 4;

  // Width of the reported slot number.
  localparam int ENTRY_IDX_W = 4;

  typedef logic [LANE_W-1:0] lane_idx_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

  // Position of the lowest set bit; zero when no bit is set.
  function automatic lane_idx_t first_set(input logic [LANE_MAX-1:0] v);
    lane_idx_t idx;
    idx = '0;
    for (int i = LANE_MAX - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LANE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/sftf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sftf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/sftf_ctrl.sv
// Sequencer for the sender flow table filter: load, chunked scan, write-back.
// Depends on sftf_pkg for the command and status structs.
`timescale 1ns / 1ps

module sftf_ctrl
  import sftf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_WRITE) && status.out_free;

endmodule

FILE: rtl/core/sftf_dp.sv
// Datapath of the sender flow table filter: slot table, key compare, chunked
// priority scan, table update and the result register.
// Depends on sftf_pkg and sftf_ram.
`timescale 1ns / 1ps

module sftf_dp
  import sftf_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output ctrl_status_t           status,
  input  logic [31:0]            source_address,
  input  logic [31:0]            group_address,
  input  logic [15:0]            destination_port,
  input  logic                   from_redundancy_path,
  input  logic [31:0]            now_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   accept,
  output logic                   hit,
  output logic                   table_full,
  output logic [ENTRY_IDX_W-1:0] entry_index
);

  localparam int LANES = (ENTRIES < LANE_MAX) ? ENTRIES : LANE_MAX;
  localparam int NCHUNK = (ENTRIES + LANES - 1) / LANES;
  localparam int PADDED = NCHUNK * LANES;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int LAST_CHUNK = NCHUNK - 1;

  // Slot table. Keys sit in flops so every slot has its own comparator.
  logic [ENTRIES-1:0] slot_valid;
  logic [ENTRIES-1:0] slot_enabled;
  logic [31:0]        slot_source [ENTRIES];
  logic [31:0]        slot_group [ENTRIES];
  logic [15:0]        slot_port [ENTRIES];

  // Header of the packet in work.
  logic [31:0] hdr_source;
  logic [31:0] hdr_group;
  logic [15:0] hdr_port;
  logic        hdr_red;
  logic [31:0] hdr_now;

  logic [PADDED-1:0] match_now, free_now, en_now;
  logic [PADDED-1:0] match_vec, free_vec, en_vec;

  logic [CW-1:0] chunk;
  logic          found, free_found, match_en;
  logic [IW-1:0] match_idx, free_idx;

  logic [LANES-1:0] m_slice, f_slice, e_slice, m_one;
  logic             m_any, f_any;
  lane_idx_t        m_lo, f_lo;
  logic [IW-1:0]    base;

  logic [IW-1:0] sel;
  logic          full;
  logic          en_next;

  always_comb begin
    match_now = '0;
    free_now  = '0;
    en_now    = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      match_now[k] = slot_valid[k] && (slot_source[k] == source_address) &&
                     (slot_group[k] == group_address) && (slot_port[k] == destination_port);
      free_now[k]  = !slot_valid[k];
      en_now[k]    = slot_enabled[k];
    end
  end

  // Current chunk of the registered match and free vectors.
  always_comb begin
    m_slice = match_vec[int'(chunk) * LANES +: LANES];
    f_slice = free_vec[int'(chunk) * LANES +: LANES];
    e_slice = en_vec[int'(chunk) * LANES +: LANES];
    m_one   = m_slice & (~m_slice + LANES'(1));
    m_any   = |m_slice;
    f_any   = |f_slice;
    m_lo    = first_set(LANE_MAX'(m_slice));
    f_lo    = first_set(LANE_MAX'(f_slice));
    base    = IW'(chunk) * IW'(LANES);
  end

  assign status.scan_done = m_any || (chunk == CW'(LAST_CHUNK));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdr_source <= source_address;
      hdr_group  <= group_address;
      hdr_port   <= destination_port;
      hdr_red    <= from_redundancy_path;
      hdr_now    <= now_time;
      match_vec  <= match_now;
      free_vec   <= free_now;
      en_vec     <= en_now;
    end
    if (cmd.scan) begin
      if (!found && m_any) begin
        match_idx <= base + IW'(m_lo);
        match_en  <= |(m_one & e_slice);
      end
      if (!free_found && f_any) begin
        free_idx <= base + IW'(f_lo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk      <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      chunk      <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (m_any) begin
        found <= 1'b1;
      end
      if (f_any) begin
        free_found <= 1'b1;
      end
      if (chunk != CW'(LAST_CHUNK)) begin
        chunk <= chunk + CW'(1);
      end
    end
  end

  // A hit keeps its enabled mark unless this transfer came via the redundancy path;
  // a fresh insert takes the mark from the flag alone.
  assign sel     = found ? match_idx : free_idx;
  assign full    = !found && !free_found;
  assign en_next = hdr_red || (found && match_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit && !full) begin
      slot_valid[sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !full) begin
      slot_enabled[sel] <= en_next;
      if (!found) begin
        slot_source[sel] <= hdr_source;
        slot_group[sel]  <= hdr_group;
        slot_port[sel]   <= hdr_port;
      end
    end
  end

  // Last-seen stamps are only written here; the read port is left unconnected.
  sftf_ram #(
    .WIDTH(32),
    .DEPTH(ENTRIES)
  ) u_last_seen (
    .clk    (clk),
    .wr_en  (cmd.commit && !full),
    .wr_addr(sel),
    .wr_data(hdr_now),
    .rd_addr('0),
    .rd_data()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accept      <= full || hdr_red || !(found && match_en);
      hit         <= found;
      table_full  <= full;
      entry_index <= full ? '0 : ENTRY_IDX_W'(sel);
    end
  end

endmodule

FILE: rtl/core/sender_flow_table_filter_unit.sv
// Top level of the sender flow table filter.
// Depends on sftf_pkg, sftf_ctrl, sftf_dp and sftf_ram.
`timescale 1ns / 1ps

// Filters packet headers against a table of TABLE_ENTRIES sender slots keyed on
// source address, group address and destination port. A miss inserts the key in
// the lowest free slot; a hit or insert stamps the last-seen time. The packet is
// accepted when it came via the redundancy path or its slot is not enabled. A
// miss on a full table leaves the table untouched and reports table_full with
// accept set. Items are handled one at a time: the accept cycle compares the key
// against every slot at once, then the match and free vectors are scanned 16
// slots per cycle, then the write state writes the slot and loads the result
// register. The scan covers 1 up to ceil(TABLE_ENTRIES/16) chunks of 16 slots,
// stopping at the first matching chunk. A stalled result holds the write state
// until the previous result is taken. No clearing pass is needed after reset.
module sender_flow_table_filter_unit
  import sftf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            source_address,
  input  logic [31:0]            group_address,
  input  logic [15:0]            destination_port,
  input  logic                   from_redundancy_path,
  input  logic [31:0]            now_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   accept,
  output logic                   hit,
  output logic                   table_full,
  output logic [ENTRY_IDX_W-1:0] entry_index
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  sftf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  sftf_dp #(
    .ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .source_address      (source_address),
    .group_address       (group_address),
    .destination_port    (destination_port),
    .from_redundancy_path(from_redundancy_path),
    .now_time            (now_time),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .accept              (accept),
    .hit                 (hit),
    .table_full          (table_full),
    .entry_index         (entry_index)
  );

  // A full-table result never claims a hit, always accepts and reports slot zero.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> accept && !hit && (entry_index == '0))
    else $error("table_full result with inconsistent fields");

  // Once a transfer is taken in, the block is busy for at least the next cycle.
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transfer");

  // A new result only appears after an item was in work.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result produced while the block was idle");

endmodule

FILE: tb/sv/tb_sender_flow_table_filter_unit.sv
// Self-checking testbench for sender_flow_table_filter_unit: packet headers go in
// through a queue-fed driver and verdicts are checked against a local table model.
// Depends on sftf_pkg and the sender_flow_table_filter_unit RTL.
`timescale 1ns / 1ps

module tb_sender_flow_table_filter_unit;
  import sftf_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int RANDOM_HEADERS = 1600;
  localparam int MAX_WAIT = 17;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] grp;
    logic [15:0] port;
  } flow_key_t;

  typedef struct packed {
    flow_key_t   key;
    logic        redundant;
    logic [31:0] now;
  } header_t;

  typedef struct packed {
    logic                   accept;
    logic                   hit;
    logic                   table_full;
    logic [ENTRY_IDX_W-1:0] entry_index;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            source_address = '0;
  logic [31:0]            group_address = '0;
  logic [15:0]            destination_port = '0;
  logic                   from_redundancy_path = 1'b0;
  logic [31:0]            now_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   accept;
  logic                   hit;
  logic                   table_full;
  logic [ENTRY_IDX_W-1:0] entry_index;

  sender_flow_table_filter_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .source_address(source_address),
    .group_address(group_address),
    .destination_port(destination_port),
    .from_redundancy_path(from_redundancy_path),
    .now_time(now_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accept(accept),
    .hit(hit),
    .table_full(table_full),
    .entry_index(entry_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the sender table.
  logic        slot_used[TABLE_ENTRIES];
  flow_key_t   slot_key[TABLE_ENTRIES];
  logic        slot_enabled[TABLE_ENTRIES];
  logic [31:0] slot_last_seen[TABLE_ENTRIES];

  header_t   pending_headers[$];
  verdict_t  expected_verdicts[$];
  flow_key_t known_flows[$];

  int n_in_xfers = 0;
  int n_out_xfers = 0;
  int mismatches = 0;
  int total_headers = 0;

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      slot_used[k] = 1'b0;
      slot_key[k] = '0;
      slot_enabled[k] = 1'b0;
      slot_last_seen[k] = '0;
    end
  end

  // Looks the header up, updates the table and returns the verdict it earns.
  function automatic verdict_t filter_header(header_t h);
    verdict_t v;
    int found;
    int vacant;
    int slot;
    found = -1;
    vacant = -1;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (slot_used[k]) begin
        if (found < 0 && slot_key[k] == h.key) found = k;
      end else if (vacant < 0) begin
        vacant = k;
      end
    end
    v.accept = 1'b1;
    v.hit = 1'b0;
    v.table_full = 1'b1;
    v.entry_index = '0;
    if (found < 0 && vacant < 0) return v;
    if (found >= 0) begin
      slot = found;
      v.hit = 1'b1;
    end else begin
      slot = vacant;
      slot_used[slot] = 1'b1;
      slot_key[slot] = h.key;
      slot_enabled[slot] = h.redundant;
    end
    slot_last_seen[slot] = h.now;
    if (h.redundant) slot_enabled[slot] = 1'b1;
    v.accept = h.redundant || !slot_enabled[slot];
    v.table_full = 1'b0;
    v.entry_index = ENTRY_IDX_W'(slot);
    return v;
  endfunction

  // Each side alternates between calm stretches with no waits and busy ones.
  function automatic int next_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Queues a header and remembers its flow while the table still has room for it.
  task automatic queue_header(input logic [31:0] src, input logic [31:0] grp,
                              input logic [15:0] port, input logic redundant,
                              input logic [31:0] now);
    header_t h;
    bit seen;
    h.key.src = src;
    h.key.grp = grp;
    h.key.port = port;
    h.redundant = redundant;
    h.now = now;
    seen = 1'b0;
    foreach (known_flows[i]) if (known_flows[i] == h.key) seen = 1'b1;
    if (!seen && known_flows.size() < TABLE_ENTRIES) known_flows.push_back(h.key);
    pending_headers.push_back(h);
  endtask

  // Driver: presents one header at a time and waits a drawn gap after each transfer.
  int  gap_left = 0;
  int  n_offered = 0;
  bit  send_calm = 1'b0;

  always @(negedge clk) begin
    header_t h;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_in_xfers == n_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_headers.size() > 0) begin
        h = pending_headers.pop_front();
        source_address <= h.key.src;
        group_address <= h.key.grp;
        destination_port <= h.key.port;
        from_redundancy_path <= h.redundant;
        now_time <= h.now;
        in_valid <= 1'b1;
        n_offered++;
        gap_left = next_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs, so that the block backs up and stalls its input.
  logic receiver_hold = 1'b0;
  int   hold_left = 0;
  int   holds_done = 0;

  always @(negedge clk) begin
    if (!rst && hold_left == 0 && holds_done < 2 && n_in_xfers >= 300 + 700 * holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    receiver_hold <= (hold_left > 0);
    if (hold_left > 0) hold_left--;
  end

  int stall_left = 0;
  int results_seen = 0;
  bit recv_calm = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (n_out_xfers != results_seen) begin
        results_seen = n_out_xfers;
        stall_left = next_wait(recv_calm);
      end
      if (receiver_hold || stall_left > 0) begin
        if (stall_left > 0) stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    header_t  h;
    verdict_t got;
    verdict_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        h.key.src = source_address;
        h.key.grp = group_address;
        h.key.port = destination_port;
        h.redundant = from_redundancy_path;
        h.now = now_time;
        expected_verdicts.push_back(filter_header(h));
        n_in_xfers++;
      end
      if (out_valid && out_ready) begin
        n_out_xfers++;
        got.accept = accept;
        got.hit = hit;
        got.table_full = table_full;
        got.entry_index = entry_index;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: accept=%b hit=%b full=%b index=%0d",
                     $realtime, got.accept, got.hit, got.table_full, got.entry_index);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.accept !== want.accept || got.hit !== want.hit ||
              got.table_full !== want.table_full || got.entry_index !== want.entry_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: expected accept=%b hit=%b full=%b index=%0d, got %b %b %b %0d",
                       $realtime, n_out_xfers, want.accept, want.hit, want.table_full,
                       want.entry_index, got.accept, got.hit, got.table_full, got.entry_index);
          end
        end
      end
    end
  end

  initial begin
    flow_key_t k;
    int pick;
    // First insert, then hits that walk the enabled mark through accept and drop.
    queue_header(32'h0, 32'h0, 16'h0, 1'b0, 32'h0);
    queue_header(32'h0, 32'h0, 16'h0, 1'b0, 32'h5);
    queue_header(32'h0, 32'h0, 16'h0, 1'b1, 32'h6);
    queue_header(32'h0, 32'h0, 16'h0, 1'b0, 32'h7);
    queue_header('1, '1, '1, 1'b1, '1);
    queue_header('1, '1, '1, 1'b0, 32'h1);
    // Keys that differ from a stored one in a single field.
    queue_header('1, '1, 16'hfffe, 1'b0, 32'h2);
    queue_header('1, 32'hffff_fffe, '1, 1'b0, 32'h3);
    queue_header(32'hffff_fffe, '1, '1, 1'b1, 32'h4);
    for (int i = 5; i < TABLE_ENTRIES; i++)
      queue_header(32'(1) << i, ~(32'(1) << i), 16'(1) << i, 1'(i), 32'(i));
    // The table is now full: misses are accepted and flagged.
    queue_header(32'h1234_5678, 32'h9abc_def0, 16'h1234, 1'b0, 32'd100);
    queue_header(32'h1234_5678, 32'h9abc_def0, 16'h1234, 1'b1, 32'd101);
    queue_header(32'(1) << 15, ~(32'(1) << 15), 16'(1) << 15, 1'b0, 32'd102);
    queue_header(32'h0, 32'h0, 16'h0, 1'b1, 32'd200);

    // Mostly known flows with random flags and times, mixed with near misses and noise.
    for (int n = 0; n < RANDOM_HEADERS; n++) begin
      pick = $urandom_range(0, 99);
      k = known_flows[$urandom_range(0, known_flows.size() - 1)];
      if (pick >= 85) begin
        k.src = $urandom;
        k.grp = $urandom;
        k.port = 16'($urandom);
      end else if (pick >= 70) begin
        case ($urandom_range(0, 2))
          0: k.src ^= 32'(1) << $urandom_range(0, 31);
          1: k.grp ^= 32'(1) << $urandom_range(0, 31);
          default: k.port ^= 16'(1) << $urandom_range(0, 15);
        endcase
      end
      queue_header(k.src, k.grp, k.port, 1'($urandom_range(0, 3) == 0), $urandom);
    end
    total_headers = pending_headers.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_in_xfers < total_headers || expected_verdicts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("tb_sender_flow_table_filter_unit: clean");
    end else begin
      $display("tb_sender_flow_table_filter_unit: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sender_flow_table_filter_unit: errors");
    $finish;
  end

endmodule
